// File: hdl/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared constants, datapath operation codes and the controller command
// struct for the stereo cascaded damping lowpass.
// ----------------------------------------------------------------------------
`default_nettype none

package sdl_pkg;

  // default widths of the sample and factor formats
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FACTOR_BITS_DEF = 16;

  // fixed formats
  localparam int STATE_BITS   = 32;
  localparam int GAIN_BITS    = 15;
  localparam int GAIN_FRAC    = 14;
  localparam int GAIN_RESET   = 16384;
  localparam int FACTOR_RESET = 32768;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  // one step of the sequence, each run on the shared multiplier
  typedef enum logic [2:0] {
    OP_FIRST  = 3'd0,
    OP_SECOND = 3'd1,
    OP_AIR    = 3'd2,
    OP_DAMP   = 3'd3,
    OP_AIRMIX = 3'd4,
    OP_GAIN   = 3'd5
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted input
    logic mul;     // register the product of the current step
    logic acc;     // shift, add and store the current step
    logic wr_out;  // write the output register
    op_e  op;
  } sdl_cmd_t;

  function automatic op_e next_op(input op_e op);
    op_e nxt;
    unique case (op)
      OP_FIRST:  nxt = OP_SECOND;
      OP_SECOND: nxt = OP_AIR;
      OP_AIR:    nxt = OP_DAMP;
      OP_DAMP:   nxt = OP_AIRMIX;
      OP_AIRMIX: nxt = OP_GAIN;
      default:   nxt = OP_FIRST;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sdl_regs.sv
// ----------------------------------------------------------------------------
// sdl_regs
// APB-style register file holding stage factors, blend weights and gain.
// ----------------------------------------------------------------------------
`default_nettype none

module sdl_regs
  import sdl_pkg::*;
#(
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output logic      [FACTOR_BITS-1:0]   first_factor_o,
  output logic      [FACTOR_BITS-1:0]   second_factor_o,
  output logic      [FACTOR_BITS-1:0]   air_factor_o,
  output logic      [FACTOR_BITS:0]     damping_mix_o,
  output logic      [FACTOR_BITS:0]     air_mix_o,
  output logic      [GAIN_BITS-1:0]     output_gain_o
);

  localparam logic [2:0] REG_FIRST  = 3'd0;
  localparam logic [2:0] REG_SECOND = 3'd1;
  localparam logic [2:0] REG_AIR    = 3'd2;
  localparam logic [2:0] REG_DAMP   = 3'd3;
  localparam logic [2:0] REG_AIRMIX = 3'd4;
  localparam logic [2:0] REG_GAIN   = 3'd5;

  logic [FACTOR_BITS-1:0] first_q, second_q, air_q;
  logic [FACTOR_BITS:0]   damp_q, airmix_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [2:0]             idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes, masked to each register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= FACTOR_BITS'(FACTOR_RESET);
      second_q <= FACTOR_BITS'(FACTOR_RESET);
      air_q    <= FACTOR_BITS'(FACTOR_RESET);
      damp_q   <= '0;
      airmix_q <= '0;
      gain_q   <= GAIN_BITS'(GAIN_RESET);
    end else if (wr_en) begin
      unique case (idx)
        REG_FIRST:  first_q  <= pwdata[FACTOR_BITS-1:0];
        REG_SECOND: second_q <= pwdata[FACTOR_BITS-1:0];
        REG_AIR:    air_q    <= pwdata[FACTOR_BITS-1:0];
        REG_DAMP:   damp_q   <= pwdata[FACTOR_BITS:0];
        REG_AIRMIX: airmix_q <= pwdata[FACTOR_BITS:0];
        REG_GAIN:   gain_q   <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_FIRST:  prdata = APB_DATA_BITS'(first_q);
      REG_SECOND: prdata = APB_DATA_BITS'(second_q);
      REG_AIR:    prdata = APB_DATA_BITS'(air_q);
      REG_DAMP:   prdata = APB_DATA_BITS'(damp_q);
      REG_AIRMIX: prdata = APB_DATA_BITS'(airmix_q);
      REG_GAIN:   prdata = APB_DATA_BITS'(gain_q);
      default:    prdata = '0;
    endcase
  end

  assign first_factor_o  = first_q;
  assign second_factor_o = second_q;
  assign air_factor_o    = air_q;
  assign damping_mix_o   = damp_q;
  assign air_mix_o       = airmix_q;
  assign output_gain_o   = gain_q;

endmodule

`default_nettype wire

// File: hdl/sdl_ctrl.sv
// ----------------------------------------------------------------------------
// sdl_ctrl
// Sequencer: accepts a sample, walks the six multiply steps and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdl_ctrl
  import sdl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output sdl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ACC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cmd_o.load   = 1'b0;
    cmd_o.mul    = 1'b0;
    cmd_o.acc    = 1'b0;
    cmd_o.wr_out = 1'b0;
    cmd_o.op     = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          op_d       = OP_FIRST;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        if (op_q == OP_GAIN) begin
          // hold the last step until the output register can take it
          if (out_free) begin
            cmd_o.acc    = 1'b1;
            cmd_o.wr_out = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.acc = 1'b1;
          op_d      = next_op(op_q);
          state_d   = ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.wr_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/sdl_dpath.sv
// ----------------------------------------------------------------------------
// sdl_dpath
// Datapath: per-channel filter states, one shared signed multiplier, the
// shift-and-add stage and the saturating output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdl_dpath
  import sdl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sdl_cmd_t                      cmd_i,
  input  wire logic                          channel_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic        [FACTOR_BITS-1:0] first_factor_i,
  input  wire logic        [FACTOR_BITS-1:0] second_factor_i,
  input  wire logic        [FACTOR_BITS-1:0] air_factor_i,
  input  wire logic        [FACTOR_BITS:0]   damping_mix_i,
  input  wire logic        [FACTOR_BITS:0]   air_mix_i,
  input  wire logic        [GAIN_BITS-1:0]   output_gain_i,
  output logic                               channel_out_o,
  output logic signed      [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int STATE_SHIFT = STATE_BITS - SAMPLE_BITS;
  localparam int DIFF_BITS   = STATE_BITS + 1;
  localparam int WB          = (FACTOR_BITS + 2 > GAIN_BITS + 1) ?
                               FACTOR_BITS + 2 : GAIN_BITS + 1;
  localparam int PW          = DIFF_BITS + WB;
  localparam int OUT_SHIFT   = GAIN_FRAC + STATE_SHIFT;

  localparam logic signed [PW-1:0] SAT_HI =
    signed'({{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [FACTOR_BITS:0] MIX_ONE = {1'b1, {FACTOR_BITS{1'b0}}};

  // per-channel filter states
  logic signed [STATE_BITS-1:0] first_q  [2];
  logic signed [STATE_BITS-1:0] second_q [2];
  logic signed [STATE_BITS-1:0] air_q    [2];

  logic                         ch_q;
  logic signed [STATE_BITS-1:0] target_q;
  logic signed [STATE_BITS-1:0] a_q, b_q, c_q, m_q;
  logic signed [STATE_BITS-1:0] from_q, from_d, to_d;
  logic signed [PW-1:0]         prod_q, prod_d;
  logic        [FACTOR_BITS:0]  weight, damp_w, airmix_w;
  logic signed [DIFF_BITS-1:0]  opa;
  logic signed [WB-1:0]         opb;
  logic signed [PW-1:0]         step_shift, y_full;
  logic signed [STATE_BITS-1:0] step_sum;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // blend weights above one act as one
  assign damp_w   = (damping_mix_i > MIX_ONE) ? MIX_ONE : damping_mix_i;
  assign airmix_w = (air_mix_i > MIX_ONE) ? MIX_ONE : air_mix_i;

  // operand select for the current step
  always_comb begin
    from_d = '0;
    to_d   = '0;
    weight = '0;
    unique case (cmd_i.op)
      OP_FIRST: begin
        from_d = first_q[ch_q];
        to_d   = target_q;
        weight = {1'b0, first_factor_i};
      end
      OP_SECOND: begin
        from_d = second_q[ch_q];
        to_d   = a_q;
        weight = {1'b0, second_factor_i};
      end
      OP_AIR: begin
        from_d = air_q[ch_q];
        to_d   = b_q;
        weight = {1'b0, air_factor_i};
      end
      OP_DAMP: begin
        from_d = a_q;
        to_d   = b_q;
        weight = damp_w;
      end
      OP_AIRMIX: begin
        from_d = m_q;
        to_d   = c_q;
        weight = airmix_w;
      end
      default: begin
        from_d = m_q;
        to_d   = '0;
        weight = '0;
      end
    endcase
  end

  // shared multiplier: difference times weight, or blend times gain
  always_comb begin
    if (cmd_i.op == OP_GAIN) begin
      opa = DIFF_BITS'(m_q);
      opb = signed'(WB'(output_gain_i));
    end else begin
      opa = DIFF_BITS'(to_d) - DIFF_BITS'(from_d);
      opb = signed'(WB'(weight));
    end
    prod_d = PW'(opa) * PW'(opb);
  end

  // shift and add, saturation of the final value
  assign step_shift = prod_q >>> FACTOR_BITS;
  assign step_sum   = from_q + step_shift[STATE_BITS-1:0];
  assign y_full     = prod_q >>> OUT_SHIFT;

  always_comb begin
    if (y_full > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y_full < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q     <= channel_i;
      target_q <= STATE_BITS'(sample_in_i) <<< STATE_SHIFT;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      from_q <= from_d;
    end
  end

  // step results
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      unique case (cmd_i.op)
        OP_FIRST:  a_q <= step_sum;
        OP_SECOND: b_q <= step_sum;
        OP_AIR:    c_q <= step_sum;
        OP_DAMP:   m_q <= step_sum;
        OP_AIRMIX: m_q <= step_sum;
        default: ;
      endcase
    end
  end

  // filter states, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        first_q[i]  <= '0;
        second_q[i] <= '0;
        air_q[i]    <= '0;
      end
    end else if (cmd_i.acc) begin
      unique case (cmd_i.op)
        OP_FIRST:  first_q[ch_q]  <= step_sum;
        OP_SECOND: second_q[ch_q] <= step_sum;
        OP_AIR:    air_q[ch_q]    <= step_sum;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_out) begin
      channel_out_o <= ch_q;
      sample_out_o  <= y_sat;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stereo_cascaded_damping_lowpass.sv
// ----------------------------------------------------------------------------
// stereo_cascaded_damping_lowpass
// Three cascaded one-pole lowpass stages per channel with damping and
// air-loss blending, output gain and saturation.
// ----------------------------------------------------------------------------
// Each accepted sample is taken in an accept state, then walks six steps
// (three stage updates, two blends, the gain) on the single shared
// multiplier, each a multiply then a shift-and-add. The result
// lands in an output register, so the next sample is accepted while the
// previous result still waits; the last step holds only while that register
// is occupied and stalled. Left and right states are selected per sample by
// channel_i and are cleared by reset. Registers lie at byte address 4*i:
// first, second and air stage factors, damping mix, air mix, output gain.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_cascaded_damping_lowpass
  import sdl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          channel_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               channel_out_o,
  output logic signed      [SAMPLE_BITS-1:0] sample_out_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [APB_ADDR_BITS-1:0] paddr,
  input  wire logic        [APB_DATA_BITS-1:0] pwdata,
  output logic             [APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  sdl_cmd_t               cmd;
  logic [FACTOR_BITS-1:0] first_factor, second_factor, air_factor;
  logic [FACTOR_BITS:0]   damping_mix, air_mix;
  logic [GAIN_BITS-1:0]   output_gain;

  // configuration registers
  sdl_regs #(
    .FACTOR_BITS(FACTOR_BITS)
  ) u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .first_factor_o (first_factor),
    .second_factor_o(second_factor),
    .air_factor_o   (air_factor),
    .damping_mix_o  (damping_mix),
    .air_mix_o      (air_mix),
    .output_gain_o  (output_gain)
  );

  // sequencer
  sdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  sdl_dpath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FACTOR_BITS(FACTOR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .channel_i      (channel_i),
    .sample_in_i    (sample_in_i),
    .first_factor_i (first_factor),
    .second_factor_i(second_factor),
    .air_factor_i   (air_factor),
    .damping_mix_i  (damping_mix),
    .air_mix_i      (air_mix),
    .output_gain_i  (output_gain),
    .channel_out_o  (channel_out_o),
    .sample_out_o   (sample_out_o)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_out |-> (!out_valid_o || !out_stall_i))
    else $error("output register written while a result is pending");

  // a new sample starts with the first stage multiply
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (cmd.mul && cmd.op == OP_FIRST))
    else $error("sequence did not start at the first stage");

  // each multiply is followed by its add with the same step
  a_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul |=> (!cmd.mul && !cmd.load && $stable(cmd.op)))
    else $error("multiply not followed by its add step");

  // no input transfer while a sample is in work
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul || cmd.acc) |-> in_stall_o)
    else $error("input not stalled during a sample");

endmodule

`default_nettype wire

// File: sim/tb_stereo_cascaded_damping_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_cascaded_damping_lowpass
// Self-checking bench for the stereo cascaded damping lowpass. A queue-fed
// driver offers samples on both channels, a bit-exact integer predictor
// tracks the three lowpass stages per channel, and a monitor compares every
// output transfer against the oldest prediction. The run walks through several
// register settings and idle patterns, including a long output hold-off.
// ----------------------------------------------------------------------------

module tb_stereo_cascaded_damping_lowpass;
  import sdl_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FACTOR_BITS_DEF;
  localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint MIX_ONE = longint'(1) << FB;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 88;
  localparam int MAX_REPORTS   = 10;

  // register map, index times four is the byte address
  typedef enum logic [2:0] {
    REG_FIRST_K  = 3'd0,
    REG_SECOND_K = 3'd1,
    REG_AIR_K    = 3'd2,
    REG_DAMP_MIX = 3'd3,
    REG_AIR_MIX  = 3'd4,
    REG_GAIN     = 3'd5,
    REG_SPARE6   = 3'd6,
    REG_SPARE7   = 3'd7
  } reg_idx_e;

  typedef struct {
    logic                 chan;
    logic signed [SB-1:0] level;
  } chan_sample_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // block ports
  logic                     in_valid_i = 1'b0;
  wire                      in_stall_o;
  logic                     channel_i = 1'b0;
  logic signed [SB-1:0]     sample_in_i = '0;
  wire                      out_valid_o;
  logic                     out_stall_i = 1'b0;
  wire                      channel_out_o;
  wire signed  [SB-1:0]     sample_out_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  wire  [APB_DATA_BITS-1:0] prdata;
  wire                      pready;

  stereo_cascaded_damping_lowpass #(
    .SAMPLE_BITS (SB),
    .FACTOR_BITS (FB)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .sample_out_o  (sample_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor copy of the registers and the per-channel stage values
  logic [FB-1:0] first_k  = FB'(FACTOR_RESET);
  logic [FB-1:0] second_k = FB'(FACTOR_RESET);
  logic [FB-1:0] air_k    = FB'(FACTOR_RESET);
  logic [FB:0]   damp_mix = '0;
  logic [FB:0]   air_mix  = '0;
  logic [GAIN_BITS-1:0] gain = GAIN_BITS'(GAIN_RESET);
  longint first_lp[2]  = '{0, 0};
  longint second_lp[2] = '{0, 0};
  longint air_lp[2]    = '{0, 0};

  chan_sample_t sample_pend_q[$];
  chan_sample_t damped_due_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycles_run = 0;
  bit          hold_go = 1'b0;
  logic        long_hold = 1'b0;

  // one-pole step toward a target, floor rounding
  function automatic longint glide(input longint from, input longint target,
                                   input longint weight);
    return from + (((target - from) * weight) >>> FB);
  endfunction

  // blend weights above one act as one
  function automatic longint mix_weight(input logic [FB:0] mix);
    return (longint'(mix) > MIX_ONE) ? MIX_ONE : longint'(mix);
  endfunction

  // advance the selected channel and work out its damped output
  function automatic chan_sample_t predict_damped(input logic chan,
                                                  input logic signed [SB-1:0] x);
    longint target, a, b, c, m, y;
    chan_sample_t r;
    target = longint'(x) * (longint'(1) << (STATE_BITS - SB));
    a = glide(first_lp[chan], target, longint'(first_k));
    b = glide(second_lp[chan], a, longint'(second_k));
    c = glide(air_lp[chan], b, longint'(air_k));
    first_lp[chan]  = a;
    second_lp[chan] = b;
    air_lp[chan]    = c;
    m = glide(a, b, mix_weight(damp_mix));
    m = glide(m, c, mix_weight(air_mix));
    y = (m * longint'(gain)) >>> GAIN_FRAC;
    y = y >>> (STATE_BITS - SB);
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    r.chan  = chan;
    r.level = y[SB-1:0];
    return r;
  endfunction

  // failure bookkeeping, only the first few are printed
  task automatic note_failure(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // input driver, predicts each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin : sample_sender
    chan_sample_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      channel_i   <= 1'b0;
      sample_in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        damped_due_q.push_back(predict_damped(channel_i, sample_in_i));
      if (!in_valid_i || !in_stall_o) begin
        if (sample_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_pend_q.pop_front();
          in_valid_i  <= 1'b1;
          channel_i   <= nxt.chan;
          sample_in_i <= nxt.level;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall driver
  always @(posedge clk_i) begin : damped_checker
    chan_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (damped_due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] unexpected transfer: channel %0d sample %0d",
                   $realtime, channel_out_o, sample_out_o);
      end else begin
        want = damped_due_q.pop_front();
        if (channel_out_o !== want.chan)
          note_failure("channel_out", longint'(want.chan), longint'(channel_out_o));
        if (sample_out_o !== want.level)
          note_failure("sample_out", longint'(want.level), longint'(sample_out_o));
      end
    end
    out_stall_i <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, lets the block fill and stall its input
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // watchdog
  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("tb_stereo_cascaded_damping_lowpass NOT OK");
    $finish;
  end

  // register write, setup then access, mirrored into the predictor
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FIRST_K:  first_k  = value[FB-1:0];
      REG_SECOND_K: second_k = value[FB-1:0];
      REG_AIR_K:    air_k    = value[FB-1:0];
      REG_DAMP_MIX: damp_mix = value[FB:0];
      REG_AIR_MIX:  air_mix  = value[FB:0];
      REG_GAIN:     gain     = value[GAIN_BITS-1:0];
      default: ;
    endcase
  endtask

  // pick a register value, biased to the extremes and to junk upper bits
  function automatic logic [31:0] pick_reg_value(input reg_idx_e idx);
    int unsigned r;
    r = $urandom_range(7);
    case (idx)
      REG_DAMP_MIX, REG_AIR_MIX: begin
        case (r)
          0: return 32'd0;
          1: return 32'(MIX_ONE);
          2: return $urandom_range((1 << (FB + 1)) - 1, (1 << FB) + 1);
          3: return $urandom;
          default: return $urandom_range(1 << FB);
        endcase
      end
      REG_GAIN: begin
        case (r)
          0: return 32'd0;
          1: return 32'd32767;
          2: return 32'(GAIN_RESET);
          3: return $urandom;
          default: return $urandom_range(32767);
        endcase
      end
      default: begin
        case (r)
          0: return 32'd0;
          1: return (1 << FB) - 1;
          2: return $urandom;
          default: return $urandom_range((1 << FB) - 1);
        endcase
      end
    endcase
  endfunction

  task automatic offer(input logic chan, input logic signed [SB-1:0] level);
    chan_sample_t item;
    item.chan  = chan;
    item.level = level;
    sample_pend_q.push_back(item);
  endtask

  // held levels with noise mixed in, so the stages settle and swing
  task automatic queue_random(input int unsigned count);
    int unsigned run_left;
    logic signed [SB-1:0] held;
    logic chan;
    run_left = 0;
    held = '0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(12, 1);
        case ($urandom_range(5))
          0: held = SB'(SAMPLE_MAX);
          1: held = SB'(SAMPLE_MIN);
          2: held = '0;
          default: held = SB'($urandom);
        endcase
      end
      run_left--;
      chan = 1'($urandom);
      if ($urandom_range(3) == 0)
        offer(chan, SB'($urandom));
      else
        offer(chan, held);
    end
  endtask

  // wait until every transfer is through, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_pend_q.size() != 0 || in_valid_i || damped_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // reset settings: full-scale steps, zero, small values, bit patterns
    offer(1'b0, SB'(SAMPLE_MAX));
    offer(1'b0, SB'(SAMPLE_MAX));
    offer(1'b0, SB'(SAMPLE_MAX));
    offer(1'b1, SB'(SAMPLE_MIN));
    offer(1'b0, SB'(SAMPLE_MIN));
    offer(1'b0, SB'(SAMPLE_MIN));
    offer(1'b1, '0);
    offer(1'b0, SB'(-1));
    offer(1'b0, SB'(1));
    offer(1'b1, SB'(24'h555555));
    offer(1'b1, SB'(24'hAAAAAA));
    offer(1'b1, SB'(SAMPLE_MAX));
    wait_drained();

    // fastest stages, mixes above one, gain near two, junk upper bits
    reg_write(REG_FIRST_K, (1 << FB) - 1);
    reg_write(REG_SECOND_K, (1 << FB) - 1);
    reg_write(REG_AIR_K, 32'hFFFF_FFFF);
    reg_write(REG_DAMP_MIX, (1 << (FB + 1)) - 1);
    reg_write(REG_AIR_MIX, 32'hFFFF_FFFF);
    reg_write(REG_GAIN, 32'hFFFF_FFFF);
    // unmapped registers, writes must be ignored
    reg_write(REG_SPARE6, 32'hDEAD_BEEF);
    reg_write(REG_SPARE7, 32'h0000_0000);
    repeat (2) begin
      offer(1'b0, SB'(SAMPLE_MAX));
      offer(1'b1, SB'(SAMPLE_MIN));
    end
    offer(1'b0, SB'(SAMPLE_MIN));
    offer(1'b0, SB'(SAMPLE_MIN));
    offer(1'b1, SB'(SAMPLE_MAX));
    offer(1'b1, SB'(1 << (SB - 2)));
    offer(1'b1, SB'(-(1 << (SB - 2)) - 1));
    offer(1'b0, '0);
    wait_drained();

    // random phases, each with fresh settings and its own idle pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int r = int'(REG_FIRST_K); r <= int'(REG_GAIN); r++)
        reg_write(reg_idx_e'(r), pick_reg_value(reg_idx_e'(r)));
      @(negedge clk_i);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (ph == 0) hold_go = 1'b1;
      queue_random(PHASE_ITEMS);
      if (ph < RANDOM_PHASES - 1) wait_drained();
    end

    // final drain, leftovers count as failures
    while (sample_pend_q.size() != 0 || in_valid_i) @(negedge clk_i);
    waited = 0;
    while (damped_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (damped_due_q.size() != 0) begin
      $display("%0d expected transfers never arrived", damped_due_q.size());
      fail_count += damped_due_q.size();
    end
    if (fail_count == 0) begin
      $display("tb_stereo_cascaded_damping_lowpass OK");
    end else begin
      $display("tb_stereo_cascaded_damping_lowpass NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/sdl_pkg.sv
hdl/sdl_regs.sv
hdl/sdl_ctrl.sv
hdl/sdl_dpath.sv
hdl/stereo_cascaded_damping_lowpass.sv
sim/tb_stereo_cascaded_damping_lowpass.sv
